>>> rtl/arxbc_pkg.sv
`default_nettype none

package arxbc_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned BLOCK_W = 64;
	localparam int unsigned NUM_KEY_WORDS = 8;
	localparam int unsigned KEY_SEL_W = 3;
	localparam int unsigned NUM_KEY_REGS = 4;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned ROT_KEY = 3;
	localparam int unsigned ROT_LEFT_WORD = 2;
	localparam int unsigned ROT_RIGHT_WORD = 7;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_EXPAND,
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	function automatic word_t rol_key(input word_t v);
		return {v[WORD_W-ROT_KEY-1:0], v[WORD_W-1:WORD_W-ROT_KEY]};
	endfunction

	function automatic word_t rol_right(input word_t v);
		return {v[WORD_W-ROT_RIGHT_WORD-1:0], v[WORD_W-1:WORD_W-ROT_RIGHT_WORD]};
	endfunction

	function automatic word_t ror_right(input word_t v);
		return {v[ROT_RIGHT_WORD-1:0], v[WORD_W-1:ROT_RIGHT_WORD]};
	endfunction

	function automatic word_t rol_left(input word_t v);
		return {v[WORD_W-ROT_LEFT_WORD-1:0], v[WORD_W-1:WORD_W-ROT_LEFT_WORD]};
	endfunction

	function automatic word_t ror_left(input word_t v);
		return {v[ROT_LEFT_WORD-1:0], v[WORD_W-1:ROT_LEFT_WORD]};
	endfunction

endpackage

`default_nettype wire

>>> rtl/arxbc_ram.sv
`default_nettype none

module arxbc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/arx_block_cipher_64_256_core.sv
// 64-bit add-rotate-xor block cipher with a 256-bit key, one block at a time.
// The key is written through the configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data) as four 64-bit registers, index 0 to 3; writes to
// other indexes are ignored. Every key write, and reset, starts an expansion
// of the round keys into the round key memory; in_ready stays low meanwhile.
// Reset loads the all-zero key. An input beat (in_valid, in_ready, cmd,
// block_in) carries one block and a command: 0 encrypts, 1 decrypts. One
// round is computed per cycle, the round key being read from the memory in
// the cycle before its round. After the last round the result is written to
// the output register, and a new block can be taken no sooner than that,
// together with the write; a block is not taken while one is in the rounds.
// The output register holds its beat until out_ready is high. A block can be
// accepted while a result waits; if the previous result is still held when
// the next one finishes, the core waits with in_ready low until it is taken.
`default_nettype none

module arx_block_cipher_64_256_core
	import arxbc_pkg::*;
#(
	parameter int unsigned NUM_ROUNDS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 cmd,
	input  wire logic [BLOCK_W-1:0]   block_in,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [BLOCK_W-1:0]   block_out,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BLOCK_W-1:0]   cfg_data
);

	localparam int unsigned IDX_W = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
	localparam int unsigned CNT_W = $clog2(NUM_ROUNDS + 1);
	localparam int unsigned RAM_DEPTH = 1 << IDX_W;
	localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_ROUNDS - 1);

	state_t state_q, state_d;

	logic [BLOCK_W-1:0] key_q [NUM_KEY_REGS];
	word_t kw_q [NUM_KEY_WORDS];
	logic [KEY_SEL_W-1:0] kj_q;
	word_t prev_q;
	logic [CNT_W-1:0] cnt_q;
	logic dec_q;
	word_t l_q, r_q;
	logic out_valid_q;
	logic [BLOCK_W-1:0] block_out_q;

	logic cfg_wr, in_acc, slot_free, finish_go;
	logic [CNT_W-1:0] cnt_nxt, cnt_rd;
	logic dir_rd;
	logic [CNT_W-1:0] addr_full;
	logic [IDX_W-1:0] raddr;
	word_t rk;
	word_t kw_sum, exp_val;
	word_t l_enc, r_enc, l_dec, r_dec, l_nxt, r_nxt;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && (cfg_index < CFG_IDX_W'(NUM_KEY_REGS));
	assign slot_free = !out_valid_q || out_ready;
	assign in_acc = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign block_out = block_out_q;

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		finish_go = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				state_d = ST_EXPAND;
			end
			ST_EXPAND: begin
				if (cnt_q == LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cnt_q == LAST) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					finish_go = 1'b1;
					in_ready = 1'b1;
					state_d = in_valid ? ST_RUN : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
		if (cfg_wr) begin
			state_d = ST_LOAD;
			in_ready = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Round key read address: the first round on acceptance, the next round while running.
	assign cnt_nxt = cnt_q + CNT_W'(1);
	assign cnt_rd = in_acc ? '0 : cnt_nxt;
	assign dir_rd = in_acc ? cmd : dec_q;
	assign addr_full = dir_rd ? (LAST - cnt_rd) : cnt_rd;
	assign raddr = addr_full[IDX_W-1:0];

	assign kw_sum = rol_key(kw_q[kj_q]) + prev_q;
	assign exp_val = (cnt_q == '0) ? kw_q[0] : (kw_sum ^ WORD_W'(cnt_q));

	arxbc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(RAM_DEPTH)
	) u_rk_ram (
		.clk  (clk),
		.we   (state_q == ST_EXPAND),
		.waddr(cnt_q[IDX_W-1:0]),
		.wdata(exp_val),
		.raddr(raddr),
		.rdata(rk)
	);

	assign l_enc = (ror_left(l_q) + r_q) ^ rk;
	assign r_enc = rol_right(r_q) ^ l_enc;
	assign r_dec = ror_right(r_q ^ l_q);
	assign l_dec = rol_left((l_q ^ rk) - r_dec);
	assign l_nxt = dec_q ? l_dec : l_enc;
	assign r_nxt = dec_q ? r_dec : r_enc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEY_REGS; i++) begin
				key_q[i] <= '0;
			end
			cnt_q <= '0;
			kj_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				key_q[cfg_index[1:0]] <= cfg_data;
			end
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					cnt_q <= '0;
					kj_q <= '0;
				end
				ST_EXPAND: begin
					cnt_q <= cnt_nxt;
					kj_q <= kj_q + KEY_SEL_W'(1);
				end
				ST_RUN: begin
					cnt_q <= cnt_nxt;
				end
				ST_IDLE, ST_FINISH: begin
					if (in_acc) begin
						cnt_q <= '0;
					end
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			for (int i = 0; i < NUM_KEY_WORDS; i++) begin
				kw_q[i] <= key_q[i / 2][(i % 2) * WORD_W +: WORD_W];
			end
		end
		if (state_q == ST_EXPAND) begin
			if (cnt_q != '0) begin
				kw_q[kj_q] <= kw_sum;
			end
			prev_q <= exp_val;
		end
		if (in_acc) begin
			dec_q <= cmd;
			l_q <= block_in[WORD_W-1:0];
			r_q <= block_in[BLOCK_W-1:WORD_W];
		end else if (state_q == ST_RUN) begin
			l_q <= l_nxt;
			r_q <= r_nxt;
		end
		if (finish_go) begin
			block_out_q <= {r_q, l_q};
		end
	end

endmodule

`default_nettype wire

>>> rtl/arxbc_chk.sv
`default_nettype none

module arxbc_chk
	import arxbc_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [BLOCK_W-1:0]   block_out,
	input wire logic                 cfg_valid,
	input wire logic                 cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index
);

	// A result beat that is not taken stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(block_out))
		else $error("result beat dropped or changed while stalled");

	// A block is worked on alone: no second beat is taken in the next cycle.
	a_one_block: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a block is in the rounds");

	// A key write starts a new expansion, which blocks input.
	a_key_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_KEY_REGS)) |=> !in_ready)
		else $error("input taken during round key expansion");

	// Input is never taken in the same cycle as a key write.
	a_key_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && (cfg_index < CFG_IDX_W'(NUM_KEY_REGS)) |-> !in_ready)
		else $error("input taken together with a key write");

endmodule

bind arx_block_cipher_64_256_core arxbc_chk u_arxbc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.block_out(block_out),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready),
	.cfg_index(cfg_index)
);

`default_nettype wire
